### sv/kdq_pkg.sv
package kdq_pkg;

   localparam int TIME_W     = 32;
   localparam int DEB_W      = 8;
   localparam int DET_W      = 4;
   localparam int CSR_DATA_W = 8;
   localparam int COUNT_W    = 5;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd8;
   localparam logic [DET_W-1:0] DETENT_RESET   = 4'd4;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_DETENT   = 1'b1
   } kdq_csr_index_type;

   typedef enum logic [0:0] {
      REQ_SCAN    = 1'b0,
      REQ_SUSPEND = 1'b1
   } kdq_req_kind_type;

   typedef struct packed {
      logic stable;
      logic rise;
      logic fall;
   } kdq_lane_status_type;

   typedef struct packed {
      logic left;
      logic right;
   } kdq_turn_type;

   // Gray-code transition table indexed by {previous A, previous B, A, B}.
   function automatic logic signed [1:0] quad_delta(input logic [3:0] hist);
      logic signed [1:0] d;
      d = 2'sd0;
      case (hist) inside
         4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
         default:                  d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

### sv/kdq_if.sv
interface kdq_req_if #(parameter int NUM_KEYS = 10);
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [31:0]           now_ms;
   logic [NUM_KEYS-1:0]   key_levels_n;
   logic                  switch_level_n;
   logic                  phase_a;
   logic                  phase_b;

   modport source(output valid, req_type, now_ms, key_levels_n, switch_level_n,
                  phase_a, phase_b, input ready);
   modport sink(input valid, req_type, now_ms, key_levels_n, switch_level_n,
                phase_a, phase_b, output ready);
endinterface

interface kdq_rsp_if #(parameter int NUM_KEYS = 10);
   logic                  valid;
   logic                  ready;
   logic [NUM_KEYS-1:0]   keys_stable;
   logic [NUM_KEYS-1:0]   keys_pressed_edge;
   logic                  switch_level;
   logic                  switch_press_edge;
   logic                  turn_left;
   logic                  turn_right;
   logic [31:0]           switch_hold_ms;

   modport source(output valid, keys_stable, keys_pressed_edge, switch_level,
                  switch_press_edge, turn_left, turn_right, switch_hold_ms,
                  input ready);
   modport sink(input valid, keys_stable, keys_pressed_edge, switch_level,
                switch_press_edge, turn_left, turn_right, switch_hold_ms,
                output ready);
endinterface

### sv/key_debounce_quadrature_scanner_unit.sv
// Key debounce and quadrature scanner.
// The req channel carries scan words (timestamp, active-low key and switch
// levels, encoder phases) or suspend words; every accepted word yields exactly
// one rsp word with the debounced keys, their press edges, the switch state,
// press edge and hold time, and the left/right detent pulses.
// Each key and the switch run in their own debounce lane side by side; the
// quadrature decoder runs next to them and the top level merges the lane
// results into one registered rsp word.
// The result of an accepted word is registered and shown on rsp in the cycle
// after it is accepted. Throughput is one word per cycle while rsp.ready is
// high, set by each lane's single compare-and-update and the one output register.
// When the receiver stalls, the output register holds its word and req.ready
// drops until it is taken; ready stays high while the register is empty or
// drains in the same cycle.
// Reset (synchronous, active high) clears all debounce state, the suspend
// flag, the decoder, and loads a debounce time of 8 ms and 4 quarters a detent.
// The csr port writes the debounce time (index 0) and the quarters a detent
// (index 1); write only while no word is in flight.
module key_debounce_quadrature_scanner_unit import kdq_pkg::*; #(
   parameter int NUM_KEYS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   kdq_req_if.sink               req,
   kdq_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  kdq_csr_index_type     csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DEB_W-1:0]    debounce_ff;
   logic [DET_W-1:0]    detent_ff;

   logic                accept, scan, suspend;
   kdq_lane_status_type key_status [NUM_KEYS];
   kdq_lane_status_type sw_status;
   kdq_turn_type        turn;

   logic [NUM_KEYS-1:0] keys_stable_in, keys_edge_in;
   logic                suspended_ff, suspended_in;
   logic [TIME_W-1:0]   press_start_ff, press_start_in;
   logic [TIME_W-1:0]   hold_in;

   logic                rsp_valid_ff;
   logic [NUM_KEYS-1:0] keys_stable_ff, keys_edge_ff;
   logic                switch_level_ff, switch_edge_ff, left_ff, right_ff;
   logic [TIME_W-1:0]   hold_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         detent_ff   <= DETENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_wdata[DEB_W-1:0];
            CSR_DETENT:   detent_ff   <= csr_wdata[DET_W-1:0];
            default:      ;
         endcase
      end
   end

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign scan      = accept && (req.req_type == REQ_SCAN);
   assign suspend   = accept && (req.req_type == REQ_SUSPEND);

   for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
      kdq_debounce_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .enable  (scan),
         .raw     (!req.key_levels_n[i]),
         .now_ms  (req.now_ms),
         .deb_ms  (debounce_ff),
         .status  (key_status[i])
      );
      assign keys_stable_in[i] = key_status[i].stable;
      assign keys_edge_in[i]   = key_status[i].rise;
   end

   kdq_debounce_lane u_switch (
      .clock   (clock),
      .reset   (reset),
      .enable  (scan),
      .raw     (!req.switch_level_n),
      .now_ms  (req.now_ms),
      .deb_ms  (debounce_ff),
      .status  (sw_status)
   );

   kdq_quad u_quad (
      .clock           (clock),
      .reset           (reset),
      .enable          (scan),
      .phase_a         (req.phase_a),
      .phase_b         (req.phase_b),
      .detent_quarters (detent_ff),
      .turn            (turn)
   );

   // Merge: switch bookkeeping and hold time. A press starting now has zero
   // hold time, so the hold can use the old start time in parallel with the
   // lane compare.
   always_comb begin
      suspended_in   = suspended_ff;
      press_start_in = press_start_ff;
      if (suspend) suspended_in = 1'b1;
      if (sw_status.rise) begin
         suspended_in   = 1'b0;
         press_start_in = req.now_ms;
      end else if (sw_status.fall) begin
         press_start_in = '0;
      end
      hold_in = (sw_status.stable && !sw_status.rise && (press_start_ff != '0))
                ? req.now_ms - press_start_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         suspended_ff   <= 1'b0;
         press_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         suspended_ff   <= suspended_in;
         press_start_ff <= press_start_in;
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         keys_stable_ff  <= keys_stable_in;
         keys_edge_ff    <= keys_edge_in;
         switch_level_ff <= sw_status.stable && !suspended_in;
         switch_edge_ff  <= sw_status.rise;
         left_ff         <= turn.left;
         right_ff        <= turn.right;
         hold_ff         <= hold_in;
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.keys_stable       = keys_stable_ff;
   assign rsp.keys_pressed_edge = keys_edge_ff;
   assign rsp.switch_level      = switch_level_ff;
   assign rsp.switch_press_edge = switch_edge_ff;
   assign rsp.turn_left         = left_ff;
   assign rsp.turn_right        = right_ff;
   assign rsp.switch_hold_ms    = hold_ff;

   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.turn_left && rsp.turn_right))
      else $error("left and right pulses in the same word");

   a_switch_edge_level: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.switch_press_edge) |-> rsp.switch_level)
      else $error("switch press edge without pressed level");

   a_key_edge_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.keys_pressed_edge & ~rsp.keys_stable) == '0))
      else $error("key press edge on a key that is not stable pressed");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> rsp.valid)
      else $error("accepted word produced no result");

endmodule

### sv/kdq_debounce_lane.sv
module kdq_debounce_lane import kdq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                raw,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [DEB_W-1:0]    deb_ms,
   output kdq_lane_status_type status
);

   logic              seen_ff, seen_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] when_ff, when_in;
   logic [TIME_W-1:0] elapsed;
   logic              change;

   always_comb begin
      seen_in   = seen_ff;
      stable_in = stable_ff;
      when_in   = when_ff;
      // A fresh raw change restarts the timer, so it has held for zero ms.
      elapsed = (raw != seen_ff) ? '0 : now_ms - when_ff;
      change  = (stable_ff != raw) && (elapsed >= TIME_W'(deb_ms));
      if (enable) begin
         seen_in = raw;
         if (raw != seen_ff) when_in = now_ms;
         if (change) stable_in = raw;
      end
      status.stable = stable_in;
      status.rise   = enable && change && raw;
      status.fall   = enable && change && !raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= 1'b0;
         stable_ff <= 1'b0;
         when_ff   <= '0;
      end else begin
         seen_ff   <= seen_in;
         stable_ff <= stable_in;
         when_ff   <= when_in;
      end
   end

endmodule

### sv/kdq_quad.sv
module kdq_quad import kdq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             phase_a,
   input  logic             phase_b,
   input  logic [DET_W-1:0] detent_quarters,
   output kdq_turn_type     turn
);

   logic [3:0]                history_ff, history_in;
   logic signed [COUNT_W-1:0] count_ff, count_in;
   logic signed [COUNT_W-1:0] sum;
   logic signed [COUNT_W-1:0] thr;
   logic                      right, left;

   always_comb begin
      history_in = enable ? {history_ff[1:0], phase_a, phase_b} : history_ff;
      sum   = count_ff + COUNT_W'(quad_delta(history_in));
      thr   = (detent_quarters == '0) ? COUNT_W'(1)
                                      : signed'(COUNT_W'(detent_quarters));
      right = enable && (sum >= thr);
      left  = enable && !right && (sum <= -thr);
      count_in = count_ff;
      if (enable) count_in = (right || left) ? '0 : sum;
      turn.left  = left;
      turn.right = right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         count_ff   <= '0;
      end else begin
         history_ff <= history_in;
         count_ff   <= count_in;
      end
   end

endmodule
